### src/llrs_pkg.sv
`default_nettype none
package llrs_pkg;

  localparam int ID_BYTES_DEF = 4;
  localparam int ID_WORD_BYTES = 4;
  localparam int KW_MAX = 7;
  localparam int KW_NUM = 8;
  localparam int KW_CNT_W = 3;

  localparam logic [7:0] CH_TERM  = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  // keyword text, first letter in bits 7:0, zero padded
  localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_NUM] = '{
    56'("tluafed"), 56'("ffo"), 56'("lataf"), 56'("rorre"),
    56'("gninraw"), 56'("ofni"), 56'("gubed"), 56'("esobrev")
  };
  localparam logic [KW_CNT_W-1:0] KW_LEN [KW_NUM] = '{
    3'd7, 3'd3, 3'd5, 3'd5, 3'd7, 3'd4, 3'd5, 3'd7
  };
  localparam logic signed [3:0] KW_LEVEL [KW_NUM] = '{
    -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd5, 4'sd6
  };

  typedef enum logic [7:0] {
    PH_START = 8'b0000_0001,
    PH_NEXT  = 8'b0000_0010,
    PH_APP   = 8'b0000_0100,
    PH_CTX   = 8'b0000_1000,
    PH_LVL   = 8'b0001_0000,
    PH_MINUS = 8'b0010_0000,
    PH_DONE  = 8'b0100_0000,
    PH_KEY   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic               valid;
    logic               has_rule;
    logic               status;
    logic [31:0]        app_id;
    logic [31:0]        ctx_id;
    logic signed [3:0]  level;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

### src/llrs_kw_match.sv
`default_nettype none
module llrs_kw_match
  import llrs_pkg::*;
(
  input  wire logic [8*KW_MAX-1:0]  kw_buf,
  input  wire logic [KW_CNT_W-1:0]  kw_count,
  output logic                      hit,
  output logic signed [3:0]         level
);

  always_comb begin
    hit   = 1'b0;
    level = 4'sd0;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      // unused buffer bytes stay zero, so a full-width compare is exact
      if (kw_count == KW_LEN[k] && kw_buf == KW_TEXT[k]) begin
        hit   = 1'b1;
        level = KW_LEVEL[k];
      end
    end
  end

endmodule
`default_nettype wire

### src/llrs_parser.sv
`default_nettype none
module llrs_parser
  import llrs_pkg::*;
#(
  parameter int ID_BYTES = ID_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [7:0]  ch,
  output result_t          res
);

  localparam int CntW = $clog2(ID_BYTES + 1);

  phase_t                 phase, phase_next;
  logic [CntW-1:0]        id_count, id_count_next;
  logic [31:0]            app_word, app_word_next;
  logic [31:0]            ctx_word, ctx_word_next;
  logic signed [3:0]      level_value, level_value_next;
  logic [8*KW_MAX-1:0]    kw_buf, kw_buf_next;
  logic [KW_CNT_W-1:0]    kw_count, kw_count_next;
  logic                   error_seen, error_seen_next;

  logic                   kw_hit;
  logic signed [3:0]      kw_level;

  llrs_kw_match u_kw_match (
    .kw_buf   (kw_buf),
    .kw_count (kw_count),
    .hit      (kw_hit),
    .level    (kw_level)
  );

  function automatic logic [7:0] lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'h20;
    return r;
  endfunction

  always_comb begin
    logic rule;
    logic bad;
    logic rule_end;
    logic signed [3:0] out_level;

    phase_next       = phase;
    id_count_next    = id_count;
    app_word_next    = app_word;
    ctx_word_next    = ctx_word;
    level_value_next = level_value;
    kw_buf_next      = kw_buf;
    kw_count_next    = kw_count;
    error_seen_next  = error_seen;
    res              = '0;
    rule             = 1'b0;
    bad              = error_seen;
    rule_end         = 1'b0;
    out_level        = level_value;

    if (ch == CH_TERM) begin
      if (!error_seen) begin
        unique case (phase)
          PH_NEXT: ;
          PH_MINUS, PH_DONE: rule = 1'b1;
          PH_KEY: begin
            if (kw_hit) begin
              rule      = 1'b1;
              out_level = kw_level;
            end else begin
              bad = 1'b1;
            end
          end
          default: bad = 1'b1;
        endcase
      end
      res.valid    = 1'b1;
      res.last     = 1'b1;
      res.status   = bad;
      res.has_rule = rule;
      if (rule) begin
        res.app_id = app_word;
        res.ctx_id = ctx_word;
        res.level  = out_level;
      end
      // back to the start of a new string
      phase_next       = PH_START;
      id_count_next    = '0;
      app_word_next    = '0;
      ctx_word_next    = '0;
      level_value_next = 4'sd0;
      kw_buf_next      = '0;
      kw_count_next    = '0;
      error_seen_next  = 1'b0;
    end else if (!error_seen) begin
      unique case (phase)
        PH_START, PH_NEXT, PH_APP, PH_CTX: begin
          if (phase != PH_CTX) phase_next = PH_APP;
          if (ch == CH_COLON) begin
            phase_next    = (phase == PH_CTX) ? PH_LVL : PH_CTX;
            id_count_next = '0;
          end else if (int'(id_count) < ID_BYTES) begin
            for (int b = 0; b < ID_WORD_BYTES; b++) begin
              if (int'(id_count) == b) begin
                if (phase == PH_CTX) ctx_word_next[8*b +: 8] = ch;
                else                 app_word_next[8*b +: 8] = ch;
              end
            end
            id_count_next = id_count + 1'b1;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        PH_LVL: begin
          if (ch == CH_MINUS) begin
            level_value_next = 4'sd0;
            phase_next       = PH_MINUS;
          end else if (ch >= CH_ZERO && ch < CH_SEVEN) begin
            level_value_next = $signed(ch[3:0]);
            phase_next       = PH_DONE;
          end else if (ch == CH_SEMI) begin
            error_seen_next = 1'b1;
          end else begin
            kw_buf_next[7:0] = lower(ch);
            kw_count_next    = 3'd1;
            phase_next       = PH_KEY;
          end
        end
        PH_MINUS: begin
          if (ch == CH_ONE) begin
            level_value_next = -4'sd1;
            phase_next       = PH_DONE;
          end else if (ch == CH_SEMI) begin
            rule_end = 1'b1;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        PH_DONE: begin
          if (ch == CH_SEMI) rule_end = 1'b1;
          else               error_seen_next = 1'b1;
        end
        PH_KEY: begin
          if (ch == CH_SEMI) begin
            if (kw_hit) begin
              rule_end  = 1'b1;
              out_level = kw_level;
            end else begin
              error_seen_next = 1'b1;
            end
          end else if (kw_count < 3'(KW_MAX)) begin
            for (int i = 0; i < KW_MAX; i++) begin
              if (int'(kw_count) == i) kw_buf_next[8*i +: 8] = lower(ch);
            end
            kw_count_next = kw_count + 1'b1;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        default: error_seen_next = 1'b1;
      endcase

      if (rule_end) begin
        res.valid        = 1'b1;
        res.has_rule     = 1'b1;
        res.app_id       = app_word;
        res.ctx_id       = ctx_word;
        res.level        = out_level;
        phase_next       = PH_NEXT;
        id_count_next    = '0;
        app_word_next    = '0;
        ctx_word_next    = '0;
        level_value_next = 4'sd0;
        kw_buf_next      = '0;
        kw_count_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      id_count    <= '0;
      app_word    <= '0;
      ctx_word    <= '0;
      level_value <= 4'sd0;
      kw_buf      <= '0;
      kw_count    <= '0;
      error_seen  <= 1'b0;
    end else if (en) begin
      phase       <= phase_next;
      id_count    <= id_count_next;
      app_word    <= app_word_next;
      ctx_word    <= ctx_word_next;
      level_value <= level_value_next;
      kw_buf      <= kw_buf_next;
      kw_count    <= kw_count_next;
      error_seen  <= error_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_term_restart: assert property (@(posedge clk) disable iff (rst)
    en && ch == CH_TERM |=> phase == PH_START && !error_seen && kw_count == '0)
    else $error("parser not back at string start after terminator");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_seen && !(en && ch == CH_TERM) |=> error_seen)
    else $error("error flag dropped before terminator");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> level_value >= -4'sd1 && level_value <= 4'sd6)
    else $error("level out of range in done phase");
`endif

endmodule
`default_nettype wire

### src/log_level_rule_string_parser.sv
// a byte's result passes the input register and then the result register before it is offered
// on m_tvalid, and it is taken when m_tready is high
// throughput: one byte per cycle unless the input stage stalls; the parser state updates in one step per byte
// the input stage stalls only when a result is due and the result register is still held
// reset (rst, synchronous, active high) returns the parser to the start of a string
// and empties both registers
`default_nettype none
module log_level_rule_string_parser
  import llrs_pkg::*;
#(
  parameter int ID_BYTES = ID_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // ch
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // has_rule, status, app_id, ctx_id, level, zero pad
  output logic             m_tlast    // last
);

  logic       in_valid;
  logic [7:0] in_ch;
  logic       advance;
  result_t    res;
  result_t    out_res;
  logic       out_valid;

  llrs_parser #(.ID_BYTES(ID_BYTES)) u_parser (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .ch  (in_ch),
    .res (res)
  );

  // a byte with no result can always move on
  assign advance  = in_valid && (!res.valid || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_ch <= s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) out_res <= res;
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.last;
  assign m_tdata  = {2'b00, out_res.level, out_res.ctx_id, out_res.app_id,
                     out_res.status, out_res.has_rule};

`ifndef SYNTHESIS
  a_status_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tlast)
    else $error("error status on a result that is not the terminator");

  a_rule_xor_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("rule and error status in the same transaction");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[69:2] == '0)
    else $error("fields not zero on a result without a rule");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |-> !(advance && res.valid))
    else $error("held result overwritten");
`endif

endmodule
`default_nettype wire
